### sv/gcc_pkg.sv
// Shared constants, types and helper functions for the graph components engine.
package gcc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ROW_W        = 64;
    localparam int FUNC_W       = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NBR  = 2'd2;

    // one result as it travels from the walk engine to the output stage
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [VTX_W-1:0] vertex;
        logic [CNT_W-1:0] component;
        logic             empty_res;
    } emit_t;

    typedef struct packed {
        logic push_ready;
        logic idle;
    } emit_stat_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [CNT_W-1:0] component;
        logic             last;
        logic             empty_res;
    } res_t;

    // index of the lowest set bit; isolate it, then encode
    function automatic logic [VTX_W-1:0] lowest_bit(input logic [ROW_W-1:0] w);
        logic [ROW_W-1:0] iso;
        logic [VTX_W-1:0] idx;
        iso = w & (~w + ROW_W'(1));
        idx = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (iso[i])
            begin
                idx = idx | VTX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [ROW_W-1:0] bit_of(input logic [VTX_W-1:0] v);
        return ROW_W'(1) << v;
    endfunction

endpackage

### sv/gcc_in_if.sv
// Request channel: command plus vertex operands.
interface gcc_in_if;
    logic                         valid;
    logic                         ready;
    logic [gcc_pkg::FUNC_W-1:0]   func;
    logic [gcc_pkg::VTX_W-1:0]    vertex_a;
    logic [gcc_pkg::VTX_W-1:0]    vertex_b;

    modport source (output valid, func, vertex_a, vertex_b, input ready);
    modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

### sv/gcc_out_if.sv
// Response channel: one emitted vertex per transfer.
interface gcc_out_if;
    logic                         valid;
    logic                         ready;
    logic [gcc_pkg::VTX_W-1:0]    vertex;
    logic [gcc_pkg::CNT_W-1:0]    component;
    logic                         last;
    logic                         empty_res;

    modport source (output valid, vertex, component, last, empty_res, input ready);
    modport sink   (input valid, vertex, component, last, empty_res, output ready);
endinterface

### sv/gcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/gcc_out.sv
// Output stage: one-deep hold for last-flag tagging, then the response register.
module gcc_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcc_pkg::emit_t       emit,
    output gcc_pkg::emit_stat_t  stat,
    gcc_out_if.source            rsp
);
    import gcc_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    res_t hold_reg, hold_next;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    logic out_free;
    logic push_ok;

    assign out_free = !out_valid_reg || rsp.ready;
    assign push_ok  = !hold_valid_reg || out_free;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        if (emit.push && push_ok)
        begin
            // older result is not the last one: send it on
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_next.last  = 1'b0;
            end
            hold_valid_next     = 1'b1;
            hold_next.vertex    = emit.vertex;
            hold_next.component = emit.component;
            hold_next.last      = 1'b0;
            hold_next.empty_res = emit.empty_res;
        end
        else if (emit.flush && hold_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign stat.push_ready = push_ok;
    assign stat.idle       = !hold_valid_reg;

    assign rsp.valid     = out_valid_reg;
    assign rsp.vertex    = out_reg.vertex;
    assign rsp.component = out_reg.component;
    assign rsp.last      = out_reg.last;
    assign rsp.empty_res = out_reg.empty_res;
endmodule

### sv/gcc_ctrl.sv
// Command sequencer: edge updates, depth-first walk and neighbor listing over the RAMs.
module gcc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gcc_pkg::CNT_W-1:0] vcount,
    gcc_in_if.sink                    req,
    output gcc_pkg::emit_t            emit,
    input  gcc_pkg::emit_stat_t       stat
);
    import gcc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'h0001,
        S_ADD_RD_A = 13'h0002,
        S_ADD_WR_A = 13'h0004,
        S_ADD_RD_B = 13'h0008,
        S_ADD_WR_B = 13'h0010,
        S_CC_SCAN  = 13'h0020,
        S_CC_EVAL  = 13'h0040,
        S_CC_POP   = 13'h0080,
        S_NB_RD    = 13'h0100,
        S_NB_LOAD  = 13'h0200,
        S_NB_LIST  = 13'h0400,
        S_NB_EMPTY = 13'h0800,
        S_FLUSH    = 13'h1000
    } state_t;

    state_t state_reg, state_next;

    logic [VTX_W-1:0]        va_reg, va_next;
    logic [VTX_W-1:0]        vb_reg, vb_next;
    logic [ROW_W-1:0]        visited_reg, visited_next;
    logic [CNT_W-1:0]        comp_reg, comp_next;
    logic [CNT_W-1:0]        depth_reg, depth_next;
    logic [ROW_W-1:0]        rem_reg, rem_next;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;

    logic                    adj_we, adj_re;
    logic [ADDR_W-1:0]       adj_waddr, adj_raddr;
    logic [ROW_W-1:0]        adj_wdata, adj_rdata;
    logic                    stk_we, stk_re;
    logic [ADDR_W-1:0]       stk_waddr, stk_raddr;
    logic [VTX_W-1:0]        stk_wdata, stk_rdata;

    logic [ROW_W-1:0]        live;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        row_live;
    logic [ROW_W-1:0]        cand;
    logic [ROW_W-1:0]        free;
    logic [VTX_W-1:0]        cand_idx, free_idx, rem_idx;
    logic [CNT_W-1:0]        depth_m2;
    logic                    a_ok, b_ok;

    gcc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gcc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            live[i] = CNT_W'(i) < vcount;
        end
    end

    // a row never written reads as all zero
    assign row      = adj_rdata & {ROW_W{rd_valid_reg}};
    assign row_live = row & live;
    assign cand     = row_live & ~visited_reg;
    assign free     = live & ~visited_reg;
    assign cand_idx = lowest_bit(cand);
    assign free_idx = lowest_bit(free);
    assign rem_idx  = lowest_bit(rem_reg);
    assign depth_m2 = depth_reg - CNT_W'(2);
    assign a_ok     = {1'b0, req.vertex_a} < vcount;
    assign b_ok     = {1'b0, req.vertex_b} < vcount;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        visited_next = visited_reg;
        comp_next    = comp_reg;
        depth_next   = depth_reg;
        rem_next     = rem_reg;
        adj_we       = 1'b0;
        adj_waddr    = va_reg[ADDR_W-1:0];
        adj_wdata    = row;
        adj_re       = 1'b0;
        adj_raddr    = va_reg[ADDR_W-1:0];
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[ADDR_W-1:0];
        stk_wdata    = cand_idx;
        stk_re       = 1'b0;
        stk_raddr    = depth_m2[ADDR_W-1:0];
        emit         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    va_next = req.vertex_a;
                    vb_next = req.vertex_b;
                    unique case (req.func)
                        FUNC_ADD:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = S_ADD_RD_A;
                            end
                        end
                        FUNC_COMP:
                        begin
                            visited_next = '0;
                            comp_next    = '0;
                            depth_next   = '0;
                            state_next   = S_CC_SCAN;
                        end
                        FUNC_NBR:
                        begin
                            state_next = a_ok ? S_NB_RD : S_NB_EMPTY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD_A:
            begin
                adj_re     = 1'b1;
                adj_raddr  = va_reg[ADDR_W-1:0];
                state_next = S_ADD_WR_A;
            end
            S_ADD_WR_A:
            begin
                adj_we     = 1'b1;
                adj_waddr  = va_reg[ADDR_W-1:0];
                adj_wdata  = row | bit_of(vb_reg);
                state_next = S_ADD_RD_B;
            end
            S_ADD_RD_B:
            begin
                // row A write has landed, so a self loop reads it back
                adj_re     = 1'b1;
                adj_raddr  = vb_reg[ADDR_W-1:0];
                state_next = S_ADD_WR_B;
            end
            S_ADD_WR_B:
            begin
                adj_we     = 1'b1;
                adj_waddr  = vb_reg[ADDR_W-1:0];
                adj_wdata  = row | bit_of(va_reg);
                state_next = S_IDLE;
            end
            S_CC_SCAN:
            begin
                if (free == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.push_ready)
                begin
                    emit.push      = 1'b1;
                    emit.vertex    = free_idx;
                    emit.component = comp_reg + CNT_W'(1);
                    comp_next      = comp_reg + CNT_W'(1);
                    visited_next   = visited_reg | bit_of(free_idx);
                    stk_we         = 1'b1;
                    stk_waddr      = '0;
                    stk_wdata      = free_idx;
                    depth_next     = CNT_W'(1);
                    adj_re         = 1'b1;
                    adj_raddr      = free_idx[ADDR_W-1:0];
                    state_next     = S_CC_EVAL;
                end
            end
            S_CC_EVAL:
            begin
                if (cand != '0)
                begin
                    if (stat.push_ready)
                    begin
                        emit.push      = 1'b1;
                        emit.vertex    = cand_idx;
                        emit.component = comp_reg;
                        visited_next   = visited_reg | bit_of(cand_idx);
                        stk_we         = 1'b1;
                        stk_waddr      = depth_reg[ADDR_W-1:0];
                        stk_wdata      = cand_idx;
                        depth_next     = depth_reg + CNT_W'(1);
                        adj_re         = 1'b1;
                        adj_raddr      = cand_idx[ADDR_W-1:0];
                    end
                end
                else
                begin
                    // backtrack: fetch the entry below the top
                    depth_next = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1))
                    begin
                        state_next = S_CC_SCAN;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_raddr  = depth_m2[ADDR_W-1:0];
                        state_next = S_CC_POP;
                    end
                end
            end
            S_CC_POP:
            begin
                adj_re     = 1'b1;
                adj_raddr  = stk_rdata[ADDR_W-1:0];
                state_next = S_CC_EVAL;
            end
            S_NB_RD:
            begin
                adj_re     = 1'b1;
                adj_raddr  = va_reg[ADDR_W-1:0];
                state_next = S_NB_LOAD;
            end
            S_NB_LOAD:
            begin
                rem_next   = row_live;
                state_next = (row_live == '0) ? S_NB_EMPTY : S_NB_LIST;
            end
            S_NB_LIST:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.push_ready)
                begin
                    emit.push   = 1'b1;
                    emit.vertex = rem_idx;
                    rem_next    = rem_reg & (rem_reg - ROW_W'(1));
                end
            end
            S_NB_EMPTY:
            begin
                if (stat.push_ready)
                begin
                    emit.push      = 1'b1;
                    emit.empty_res = 1'b1;
                    state_next     = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                emit.flush = 1'b1;
                if (stat.idle)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            visited_reg   <= '0;
            comp_reg      <= '0;
            depth_reg     <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            comp_reg    <= comp_next;
            depth_reg   <= depth_next;
            if (adj_we)
            begin
                row_valid_reg[adj_waddr] <= 1'b1;
            end
            if (adj_re)
            begin
                rd_valid_reg <= row_valid_reg[adj_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        rem_reg <= rem_next;
    end
endmodule

### sv/graph_connected_components.sv
// Top level of the graph connected components engine.
//
//   channel   dir   handshake      payload
//   req       in    valid/ready    func, vertex_a, vertex_b
//   rsp       out   valid/ready    vertex, component, last, empty_res
//   cfg       in    cfg_we         cfg_wdata (vertex_count)
//
// One command at a time; req.ready is high only while the sequencer is idle.
// Add edge: read-modify-write of both rows in the adjacency RAM.
// Components: depth-first walk, paced by the stack and adjacency RAM reads.
// Neighbors: one result per live neighbor; the empty result when the vertex is out of range or has none.
// Reset clears per-row valid bits at once, so no clearing pass is needed.
// A stalled rsp holds the walk in place; results are never dropped.
module graph_connected_components (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [gcc_pkg::CNT_W-1:0] cfg_wdata,
    gcc_in_if.sink                    req,
    gcc_out_if.source                 rsp
);
    import gcc_pkg::*;

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] vcount;
    emit_t            emit;
    emit_stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CNT_W'(64);
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // counts above the array size act as the full array
    assign vcount = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                              : vertex_count_reg;

    gcc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .vcount (vcount),
        .req    (req),
        .emit   (emit),
        .stat   (stat)
    );

    gcc_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .emit  (emit),
        .stat  (stat),
        .rsp   (rsp)
    );
endmodule

### sv/gcc_chk.sv
// Port-level checker for the graph components engine, bound to the top level.
module gcc_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [gcc_pkg::VTX_W-1:0] rsp_vertex,
    input logic [gcc_pkg::CNT_W-1:0] rsp_component,
    input logic                      rsp_last,
    input logic                      rsp_empty_res
);
    import gcc_pkg::*;

    // a pending result holds until transferred
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_vertex) && $stable(rsp_component)
            && $stable(rsp_last) && $stable(rsp_empty_res))
        else $error("rsp payload changed while stalled");

    // the empty answer is a single, closing, zero result
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty_res |-> rsp_last && rsp_component == '0 && rsp_vertex == '0)
        else $error("empty result malformed");

    // more results still to come: no new command may be taken
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("command accepted in the middle of a result run");
endmodule

bind graph_connected_components gcc_chk u_gcc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_vertex    (rsp.vertex),
    .rsp_component (rsp.component),
    .rsp_last      (rsp.last),
    .rsp_empty_res (rsp.empty_res)
);
